### sv/tmcw_pkg.sv
// Shared types and constants for the text-mode console writer.
// Holds the item structs, action codes and sequencer states; no dependencies.
`timescale 1ns / 1ps

package tmcw_pkg;

    typedef enum logic [2:0] {
        ACT_PUT_CHAR     = 3'd0,
        ACT_CLEAR_EOL    = 3'd1,
        ACT_CLEAR_EOD    = 3'd2,
        ACT_CLEAR_BOL    = 3'd3,
        ACT_CLEAR_ALL    = 3'd4,
        ACT_SCROLL       = 3'd5,
        ACT_PLACE_CURSOR = 3'd6,
        ACT_READ_CELL    = 3'd7
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_column;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_column_out;
        logic [15:0] cell_value;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_TAB,
        ST_SCROLL,
        ST_SCROLL_BOT,
        ST_PUSH
    } state_t;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_RETURN  = 8'h0D;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] ATTR_RESET   = 8'h07;

endpackage

### sv/text_mode_console_writer.sv
// Text-mode console writer: cell memory, cursor and the action sequencer.
// Depends on tmcw_pkg for item structs, action codes and states.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_item): one action per item.
//   Output channel (out_valid / out_stall / out_item): exactly one result
//   item per input item, in order: the cursor after the action and, for a
//   read, the cell (attribute high byte); cell_value is zero otherwise.
//   Config: cfg_we writes cfg_wdata into the text attribute (reset 7);
//   the user must do so only while no item is in flight; not enforced here.
// Sequencing (set by the single-port-write cell memory, one cell per cycle)
//   put char (plain, CR, newline w/o scroll), place, read: accept, then push
//   tab: accept, write blanks (up to TAB_WIDTH), then push
//   clear eol/bol/eod/all: accept, write the cleared cells, then push
//   scroll (or newline on last row): copy rows up, blank the last row, push
// Reset: the memory is swept to zero, one cell per cycle, over all ROWS*COLUMNS
//   cells (2000 by default); in_stall stays high until the sweep is done.
// The result sits in an output register, so a stalled receiver only holds
//   the block once the next result is ready; the next item is accepted
//   while the earlier result still waits.
module text_mode_console_writer #(
    parameter int ROWS      = 25,
    parameter int COLUMNS   = 80,
    parameter int TAB_WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tmcw_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output tmcw_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);        // memory index
    localparam int PW    = $clog2(CELLS + 1);    // pointer, can hold CELLS
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int TCW   = $clog2(TAB_WIDTH + 1);
    localparam int MW    = (TAB_WIDTH > 2) ? $clog2(TAB_WIDTH) : 1;

    // State registers
    tmcw_pkg::state_t    state_reg, state_next;
    logic [RW-1:0]       cursor_row_reg, cursor_row_next;
    logic [CW-1:0]       cursor_col_reg, cursor_col_next;
    logic [7:0]          attr_reg;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic [PW-1:0]       end_reg, end_next;
    logic [15:0]         fill_reg, fill_next;
    logic [TCW-1:0]      tab_cnt_reg, tab_cnt_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;
    logic                is_read_reg, is_read_next;
    logic                out_valid_reg, out_valid_next;
    tmcw_pkg::out_item_t out_item_reg, out_item_next;

    // Cell memory
    logic [15:0]   cell_mem [CELLS];
    logic [15:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    // Derived values
    logic          accept;
    logic          push_ok;
    logic [PW-1:0] row_base;
    logic [PW-1:0] cur_addr;
    logic [RW-1:0] trow_c;
    logic [CW-1:0] tcol_c;
    logic [PW-1:0] tgt_addr;
    logic [15:0]   blank;
    logic [CW-1:0] col_adv;
    logic          last_row;
    logic [MW-1:0] mod_rom [COLUMNS];

    // column % TAB_WIDTH as a constant table
    for (genvar g = 0; g < COLUMNS; g++) begin : g_mod
        assign mod_rom[g] = MW'(g % TAB_WIDTH);
    end

    assign accept   = in_valid && (state_reg == tmcw_pkg::ST_IDLE);
    assign in_stall = (state_reg != tmcw_pkg::ST_IDLE);
    assign push_ok  = !out_valid_reg || !out_stall;

    assign row_base = PW'(cursor_row_reg) * PW'(COLUMNS);
    assign cur_addr = row_base + PW'(cursor_col_reg);
    assign trow_c   = (in_item.target_row > 8'(ROWS - 1)) ? RW'(ROWS - 1)
                                                          : RW'(in_item.target_row);
    assign tcol_c   = (in_item.target_column > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1)
                                                                : CW'(in_item.target_column);
    assign tgt_addr = PW'(trow_c) * PW'(COLUMNS) + PW'(tcol_c);
    assign blank    = {attr_reg, tmcw_pkg::CHAR_SPACE};
    assign col_adv  = (cursor_col_reg < CW'(COLUMNS - 1)) ? cursor_col_reg + CW'(1)
                                                          : cursor_col_reg;
    assign last_row = (cursor_row_reg == RW'(ROWS - 1));

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmcw_pkg::ST_CLEAR:
            begin
                if (ptr_reg == PW'(CELLS - 1))
                    state_next = tmcw_pkg::ST_IDLE;
            end
            tmcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.action)
                        tmcw_pkg::ACT_PUT_CHAR:
                        begin
                            if (in_item.char_code == tmcw_pkg::CHAR_NEWLINE && last_row)
                                state_next = tmcw_pkg::ST_SCROLL;
                            else if (in_item.char_code == tmcw_pkg::CHAR_TAB)
                                state_next = tmcw_pkg::ST_TAB;
                            else
                                state_next = tmcw_pkg::ST_PUSH;
                        end
                        tmcw_pkg::ACT_CLEAR_EOL,
                        tmcw_pkg::ACT_CLEAR_EOD,
                        tmcw_pkg::ACT_CLEAR_BOL,
                        tmcw_pkg::ACT_CLEAR_ALL: state_next = tmcw_pkg::ST_FILL;
                        tmcw_pkg::ACT_SCROLL:    state_next = tmcw_pkg::ST_SCROLL;
                        default:                 state_next = tmcw_pkg::ST_PUSH;
                    endcase
                end
            end
            tmcw_pkg::ST_FILL:
            begin
                if (ptr_reg == end_reg)
                    state_next = tmcw_pkg::ST_PUSH;
            end
            tmcw_pkg::ST_TAB:
            begin
                if (tab_cnt_reg == TCW'(1))
                    state_next = tmcw_pkg::ST_PUSH;
            end
            tmcw_pkg::ST_SCROLL:
            begin
                if (ptr_reg == PW'(CELLS - COLUMNS))
                    state_next = tmcw_pkg::ST_SCROLL_BOT;
            end
            tmcw_pkg::ST_SCROLL_BOT: state_next = tmcw_pkg::ST_FILL;
            tmcw_pkg::ST_PUSH:
            begin
                if (push_ok)
                    state_next = tmcw_pkg::ST_IDLE;
            end
            default: state_next = tmcw_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        fill_next       = fill_reg;
        tab_cnt_next    = tab_cnt_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        is_read_next    = is_read_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_item_next   = out_item_reg;
        mem_we          = 1'b0;
        mem_wa          = cur_addr[AW-1:0];
        mem_wd          = blank;
        mem_re          = 1'b0;
        mem_ra          = tgt_addr[AW-1:0];

        case (state_reg)
            tmcw_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = ptr_reg[AW-1:0];
                mem_wd   = '0;
                ptr_next = ptr_reg + PW'(1);
            end
            tmcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    is_read_next = (in_item.action == tmcw_pkg::ACT_READ_CELL);
                    fill_next    = blank;
                    case (in_item.action)
                        tmcw_pkg::ACT_PUT_CHAR:
                        begin
                            if (in_item.char_code == tmcw_pkg::CHAR_NEWLINE)
                            begin
                                cursor_col_next = '0;
                                if (last_row)
                                begin
                                    ptr_next     = '0;
                                    wr_pend_next = 1'b0;
                                end
                                else
                                    cursor_row_next = cursor_row_reg + RW'(1);
                            end
                            else if (in_item.char_code == tmcw_pkg::CHAR_TAB)
                                tab_cnt_next = TCW'(TAB_WIDTH) -
                                               TCW'(mod_rom[cursor_col_reg]);
                            else if (in_item.char_code != tmcw_pkg::CHAR_RETURN)
                            begin
                                mem_we          = 1'b1;
                                mem_wd          = {attr_reg, in_item.char_code};
                                cursor_col_next = col_adv;
                            end
                        end
                        tmcw_pkg::ACT_CLEAR_EOL:
                        begin
                            ptr_next = cur_addr;
                            end_next = row_base + PW'(COLUMNS);
                        end
                        tmcw_pkg::ACT_CLEAR_EOD:
                        begin
                            ptr_next = cur_addr;
                            end_next = PW'(CELLS);
                        end
                        tmcw_pkg::ACT_CLEAR_BOL:
                        begin
                            ptr_next = row_base;
                            end_next = cur_addr;
                        end
                        tmcw_pkg::ACT_CLEAR_ALL:
                        begin
                            ptr_next = '0;
                            end_next = PW'(CELLS);
                        end
                        tmcw_pkg::ACT_SCROLL:
                        begin
                            ptr_next     = '0;
                            wr_pend_next = 1'b0;
                        end
                        tmcw_pkg::ACT_PLACE_CURSOR:
                        begin
                            cursor_row_next = trow_c;
                            cursor_col_next = tcol_c;
                        end
                        tmcw_pkg::ACT_READ_CELL: mem_re = 1'b1;
                        default: ;
                    endcase
                end
            end
            tmcw_pkg::ST_FILL:
            begin
                if (ptr_reg != end_reg)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = ptr_reg[AW-1:0];
                    mem_wd   = fill_reg;
                    ptr_next = ptr_reg + PW'(1);
                end
            end
            tmcw_pkg::ST_TAB:
            begin
                mem_we          = 1'b1;
                cursor_col_next = col_adv;
                tab_cnt_next    = tab_cnt_reg - TCW'(1);
            end
            tmcw_pkg::ST_SCROLL:
            begin
                // copy pipeline: read row below now, write it in the next cycle
                if (wr_pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = wr_addr_reg;
                    mem_wd = rd_data_reg;
                end
                mem_re = 1'b1;
                if (ptr_reg != PW'(CELLS - COLUMNS))
                begin
                    mem_ra       = AW'(ptr_reg + PW'(COLUMNS));
                    wr_pend_next = 1'b1;
                    wr_addr_next = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + PW'(1);
                end
                else
                begin
                    // old bottom row's first cell is still in place
                    mem_ra       = AW'(CELLS - COLUMNS);
                    wr_pend_next = 1'b0;
                end
            end
            tmcw_pkg::ST_SCROLL_BOT:
            begin
                fill_next = {rd_data_reg[15:8], tmcw_pkg::CHAR_SPACE};
                ptr_next  = PW'(CELLS - COLUMNS);
                end_next  = PW'(CELLS);
            end
            tmcw_pkg::ST_PUSH:
            begin
                if (push_ok)
                begin
                    out_valid_next                  = 1'b1;
                    out_item_next.cursor_row_out    = 5'(cursor_row_reg);
                    out_item_next.cursor_column_out = 7'(cursor_col_reg);
                    out_item_next.cell_value        = is_read_reg ? rd_data_reg : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tmcw_pkg::ST_CLEAR;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            attr_reg       <= tmcw_pkg::ATTR_RESET;
            ptr_reg        <= '0;
            tab_cnt_reg    <= '0;
            wr_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            ptr_reg        <= ptr_next;
            tab_cnt_reg    <= tab_cnt_next;
            wr_pend_reg    <= wr_pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                attr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg      <= end_next;
        fill_reg     <= fill_next;
        wr_addr_reg  <= wr_addr_next;
        is_read_reg  <= is_read_next;
        out_item_reg <= out_item_next;
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= cell_mem[mem_ra];
    end

    // Assertions
    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_row_reg <= RW'(ROWS - 1)) && (cursor_col_reg <= CW'(COLUMNS - 1)))
        else $error("cursor out of range");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !accept)
        else $error("item accepted while previous one in progress");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmcw_pkg::ST_FILL) |-> (ptr_reg <= end_reg) && (end_reg <= PW'(CELLS)))
        else $error("fill pointer past end");

    a_push_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmcw_pkg::ST_PUSH) && push_ok |=> out_valid_reg)
        else $error("result not loaded into output register");

    a_scroll_write_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmcw_pkg::ST_SCROLL_BOT) |-> !wr_pend_reg)
        else $error("scroll copy left a pending write");

endmodule
